// File: design/narsmp_pkg.sv
// ----------------------------------------------------------------------------
// narsmp_pkg
// Shared constants for the normal accept/reject sampler pipeline.
// ----------------------------------------------------------------------------
package narsmp_pkg;

  // ln(2) as an unsigned Q0.32 fraction
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Rounds of log2 squaring, one bit of fraction per round
  localparam int LOG_ROUNDS = 32;

  // Register stages of one negative-log lane: normalize, rounds, t, products, sum
  localparam int LN_LAT = LOG_ROUNDS + 4;

  // Register stages of the acceptance test after the lanes
  localparam int ACC_LAT = 3;

endpackage

// File: design/narsmp_ln_lane.sv
// ----------------------------------------------------------------------------
// narsmp_ln_lane
// Pipelined natural negative log of an F-bit fraction, result in Q.32.
// ----------------------------------------------------------------------------
module narsmp_ln_lane import narsmp_pkg::*; #(
  parameter int F = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [F-1:0]              m,
  output logic [$clog2(F+1)+31:0]   x
);

  localparam int PW = $clog2(F);
  localparam int HW = $clog2(F+1);
  localparam int XW = HW + 32;

  logic [PW-1:0] pos;
  logic [63:0]   mw;
  logic [31:0]   yn;

  logic [31:0]   y_r  [0:LOG_ROUNDS];
  logic [31:0]   fr_r [0:LOG_ROUNDS];
  logic [PW-1:0] p_r  [0:LOG_ROUNDS];

  logic [HW-1:0] hi_nxt, hi_r;
  logic [31:0]   lo_nxt, lo_r;
  logic [XW-1:0] a_r;
  logic [31:0]   b_r;
  logic [XW-1:0] x_r;

  // find the top set bit and normalize to Q1.31
  always_comb begin
    pos = '0;
    for (int i = 0; i < F; i++) begin
      if (m[i]) pos = PW'(i);
    end
    mw = 64'(m);
    if (int'(pos) >= 31) begin
      yn = 32'(mw >> (int'(pos) - 31));
    end else begin
      yn = 32'(mw << (31 - int'(pos)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r[0]  <= yn;
      fr_r[0] <= '0;
      p_r[0]  <= pos;
    end
  end

  // one squaring round per stage
  for (genvar k = 0; k < LOG_ROUNDS; k++) begin : g_round
    logic [63:0] sq;
    logic [32:0] ys;
    logic [31:0] y_nxt;
    logic        bit_nxt;

    always_comb begin
      sq = 64'(y_r[k]) * 64'(y_r[k]);
      ys = 33'(sq >> 31);
      bit_nxt = ys[32];
      y_nxt = ys[32] ? ys[32:1] : ys[31:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        y_r[k+1]  <= y_nxt;
        fr_r[k+1] <= {fr_r[k][30:0], bit_nxt};
        p_r[k+1]  <= p_r[k];
      end
    end
  end

  // t = (F - p) * 2^32 - frac, split into integer and fraction
  always_comb begin
    hi_nxt = HW'(F) - HW'(p_r[LOG_ROUNDS]) - HW'(fr_r[LOG_ROUNDS] != 32'd0);
    lo_nxt = 32'd0 - fr_r[LOG_ROUNDS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
      a_r  <= XW'(64'(hi_r) * 64'(LN2_Q32));
      b_r  <= 32'((64'(lo_r) * 64'(LN2_Q32)) >> 32);
      x_r  <= a_r + XW'(b_r);
    end
  end

  assign x = x_r;

endmodule

// File: design/narsmp_accept.sv
// ----------------------------------------------------------------------------
// narsmp_accept
// Acceptance bound, comparison and output scaling of the proposal.
// ----------------------------------------------------------------------------
module narsmp_accept import narsmp_pkg::*; #(
  parameter int F = 32,
  parameter int S = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [$clog2(F+1)+31:0]   x,
  input  logic [$clog2(F+1)+31:0]   l2,
  input  logic                      u2z,
  input  logic                      neg,
  output logic                      acc,
  output logic [S+7:0]              res
);

  localparam int HW = $clog2(F+1);
  localparam int XW = HW + 32;
  localparam int OW = S + 8;
  localparam int SH = 32 - S;
  localparam logic [XW-1:0] ONE  = XW'(64'd1 << 32);
  localparam logic [63:0]   HALF = (SH > 0) ? (64'd1 << (SH - 1)) : 64'd0;
  localparam logic [63:0]   LIM  = (64'd1 << (S + 7)) - 64'd1;

  logic [XW-1:0] d;
  logic [HW-1:0] dh;

  logic [3:0]    ha_r;
  logic [31:0]   la_r;
  logic          far_a_r, far_b_r, far_c_r;
  logic [XW-1:0] x_a_r, x_b_r;
  logic [XW-1:0] l2_a_r, l2_b_r, l2_c_r;
  logic          u2z_a_r, u2z_b_r, u2z_c_r;
  logic          neg_a_r, neg_b_r, neg_c_r;
  logic [7:0]    hh_r;
  logic [35:0]   hl_r;
  logic [30:0]   ll_r;
  logic [39:0]   e_r;
  logic [63:0]   rnd;
  logic [63:0]   mag_full;
  logic [OW-1:0] mag_nxt, mag_r;

  always_comb begin
    d  = (x >= ONE) ? (x - ONE) : (ONE - x);
    dh = d[XW-1:32];
  end

  always_comb begin
    rnd      = 64'(x_b_r) + HALF;
    mag_full = rnd >> SH;
    mag_nxt  = (mag_full > LIM) ? OW'(LIM) : OW'(mag_full);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // distance from one, split
      ha_r    <= dh[3:0];
      la_r    <= d[31:0];
      far_a_r <= (dh >= HW'(16));
      x_a_r   <= x;
      l2_a_r  <= l2;
      u2z_a_r <= u2z;
      neg_a_r <= neg;
      // partial products of d*d
      hh_r    <= 8'(ha_r) * 8'(ha_r);
      hl_r    <= 36'(ha_r) * 36'(la_r);
      ll_r    <= 31'((64'(la_r) * 64'(la_r)) >> 33);
      far_b_r <= far_a_r;
      x_b_r   <= x_a_r;
      l2_b_r  <= l2_a_r;
      u2z_b_r <= u2z_a_r;
      neg_b_r <= neg_a_r;
      // bound and magnitude
      e_r     <= (40'(hh_r) << 31) + 40'(hl_r) + 40'(ll_r);
      mag_r   <= mag_nxt;
      far_c_r <= far_b_r;
      l2_c_r  <= l2_b_r;
      u2z_c_r <= u2z_b_r;
      neg_c_r <= neg_b_r;
    end
  end

  assign acc = u2z_c_r | (~far_c_r & (64'(l2_c_r) >= 64'(e_r)));
  assign res = neg_c_r ? (OW'(0) - mag_r) : mag_r;

endmodule

// File: design/normal_accept_reject_sampler.sv
// ----------------------------------------------------------------------------
// normal_accept_reject_sampler
// Standard normal samples by accept/reject from an exponential proposal.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one triple of uniform
//   fractions per transaction. Output channel (out_valid/out_stall) carries
//   one signed Q7.16 sample for each accepted triple; a rejected triple
//   produces nothing.
//   Path from input transaction to output register: input register, 36
//   stages of the negative-log lanes, 3 stages of the bound and compare,
//   output register; the input register loads at the transaction edge.
//   Throughput: one triple per cycle while the output is not stalled, set
//   by the fully pipelined squaring rounds, one multiplier per round and lane.
//   Reset clears all valid bits; the pipeline is empty afterwards.
//   When the receiver stalls with a sample pending, the whole pipeline holds
//   and in_stall is raised; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module normal_accept_reject_sampler import narsmp_pkg::*; #(
  parameter int UNIFORM_FRAC_BITS = 32,
  parameter int SAMPLE_FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [UNIFORM_FRAC_BITS-1:0]  in_first_uniform,
  input  logic [UNIFORM_FRAC_BITS-1:0]  in_second_uniform,
  input  logic [UNIFORM_FRAC_BITS-1:0]  in_third_uniform,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SAMPLE_FRAC_BITS+7:0]   out_normal_sample
);

  localparam int F   = UNIFORM_FRAC_BITS;
  localparam int OW  = SAMPLE_FRAC_BITS + 8;
  localparam int XW  = $clog2(F+1) + 32;
  localparam int VL  = 1 + LN_LAT + ACC_LAT;
  localparam logic [F-1:0] HALF_U = F'(64'd1 << (F - 1));

  logic          en;
  logic [VL-1:0] v_r;
  logic [F-1:0]  u1_r, u2_r;
  logic          sd_u2z_r [0:LN_LAT];
  logic          sd_neg_r [0:LN_LAT];
  logic [XW-1:0] x1, x2;
  logic          acc;
  logic [OW-1:0] res;
  logic          out_valid_r;
  logic [OW-1:0] out_sample_r;

  // advance whenever the output register is free or being drained
  assign en       = ~out_valid_r | ~out_stall;
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[VL-2:0], in_valid};
      out_valid_r <= v_r[VL-1] & acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r        <= (in_first_uniform == '0) ? F'(1) : in_first_uniform;
      u2_r        <= in_second_uniform;
      sd_u2z_r[0] <= (in_second_uniform == '0);
      sd_neg_r[0] <= (in_third_uniform <= HALF_U);
      for (int i = 1; i <= LN_LAT; i++) begin
        sd_u2z_r[i] <= sd_u2z_r[i-1];
        sd_neg_r[i] <= sd_neg_r[i-1];
      end
      if (v_r[VL-1] & acc) out_sample_r <= res;
    end
  end

  narsmp_ln_lane #(.F(F)) u_lane1 (
    .clk (clk),
    .en  (en),
    .m   (u1_r),
    .x   (x1)
  );

  narsmp_ln_lane #(.F(F)) u_lane2 (
    .clk (clk),
    .en  (en),
    .m   (u2_r),
    .x   (x2)
  );

  narsmp_accept #(.F(F), .S(SAMPLE_FRAC_BITS)) u_accept (
    .clk (clk),
    .en  (en),
    .x   (x1),
    .l2  (x2),
    .u2z (sd_u2z_r[LN_LAT]),
    .neg (sd_neg_r[LN_LAT]),
    .acc (acc),
    .res (res)
  );

  assign out_valid         = out_valid_r;
  assign out_normal_sample = out_sample_r;

endmodule

// File: dv/normal_accept_reject_sampler_tb.sv
// ----------------------------------------------------------------------------
// normal_accept_reject_sampler_tb
// Drives uniform triples through the sampler and predicts each sample with a
// bit-exact fixed-point negative-log and acceptance test. Accepted samples
// are compared in order; rejected triples must leave no output.
// ----------------------------------------------------------------------------
module normal_accept_reject_sampler_tb;
  import narsmp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UF = 32;
  localparam int SF = 16;
  localparam int SW = SF + 8;
  localparam int PIPE_CYCLES = 42;
  localparam int WATCHDOG_LIMIT = 3000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [UF-1:0] in_first_uniform = '0;
  logic [UF-1:0] in_second_uniform = '0;
  logic [UF-1:0] in_third_uniform = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [SW-1:0] out_normal_sample;

  logic [SW-1:0] sample_q[$];
  int            failures = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_req = 0;
  int            hold_left = 0;
  int            quiet_cycles = 0;

  normal_accept_reject_sampler #(
    .UNIFORM_FRAC_BITS(UF),
    .SAMPLE_FRAC_BITS (SF)
  ) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Natural -ln(m / 2^UF) in Q.32.
  function automatic logic [63:0] neg_log_q32(input logic [63:0] m);
    int          p;
    logic [63:0] y, frac, t;
    p = 63;
    frac = '0;
    if (m == 0) m = 1;
    while (p > 0 && m[p] == 1'b0) p--;
    if (p >= 31) y = m >> (p - 31);
    else y = m << (31 - p);
    for (int i = 0; i < LOG_ROUNDS; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    t = (64'(UF - p) << 32) - frac;
    return (t >> 32) * 64'(LN2_Q32) + (((t & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32);
  endfunction

  function automatic bit predict_sample(input logic [UF-1:0] u1, u2, u3,
                                        output logic [SW-1:0] sample);
    logic [63:0] x, d, hi, lo, bound, mag;
    x = neg_log_q32((u1 == 0) ? 64'd1 : 64'(u1));
    d = (x >= 64'h1_0000_0000) ? x - 64'h1_0000_0000 : 64'h1_0000_0000 - x;
    hi = d >> 32;
    lo = d & 64'hFFFF_FFFF;
    if (hi >= 16) bound = '1;
    else bound = ((hi * hi) << 31) + hi * lo + ((lo * lo) >> 33);
    sample = '0;
    if (u2 != 0 && neg_log_q32(64'(u2)) < bound) return 1'b0;
    mag = (x + (64'd1 << (31 - SF))) >> (32 - SF);
    if (mag > (64'd1 << (SW - 1)) - 1) mag = (64'd1 << (SW - 1)) - 1;
    if (64'(u3) <= (64'd1 << (UF - 1))) sample = SW'(-mag);
    else sample = SW'(mag);
    return 1'b1;
  endfunction

  task automatic send_triple(input logic [UF-1:0] u1, u2, u3);
    logic [SW-1:0] sample;
    bit            stalled;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_uniform <= u1;
    in_second_uniform <= u2;
    in_third_uniform <= u3;
    do begin
      @(negedge clk);
      stalled = in_stall;
      if (!stalled && predict_sample(u1, u2, u3, sample)) sample_q = {sample_q, sample};
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    wait (sample_q.size() == 0);
    repeat (PIPE_CYCLES + 4) @(posedge clk);
  endtask

  // Small u1 gives far proposals; mix widths so every exponent range shows up.
  function automatic logic [UF-1:0] rand_first();
    int w;
    w = $urandom_range(UF, 1);
    if ($urandom_range(3) != 0) return $urandom();
    return $urandom() >> (UF - w);
  endfunction

  task automatic test_directed();
    send_triple(32'h0, 32'h0, 32'h0);
    send_triple(32'h1, 32'h0, 32'hFFFF_FFFF);
    send_triple(32'h1, 32'h1, 32'h8000_0000);
    send_triple(32'h2, 32'hFFFF_FFFF, 32'h8000_0001);
    send_triple(32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
    send_triple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_triple(32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
    send_triple(32'h5E2D_58D8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_triple(32'h5E2D_58D8, 32'h0000_0001, 32'h7FFF_FFFF);
    send_triple(32'h8000_0000, 32'hC000_0000, 32'h8000_0001);
    send_triple(32'h0000_0100, 32'h0, 32'hFFFF_FFFF);
    send_triple(32'h0000_0100, 32'h0000_0001, 32'h0);
    send_triple(32'h0010_0000, 32'h0000_0010, 32'hAAAA_AAAA);
    send_triple(32'h1000_0000, 32'h5555_5555, 32'h5555_5555);
    send_triple(32'hAAAA_AAAA, 32'h2000_0000, 32'hC000_0000);
    send_triple(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333);
    drain_pipeline();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_triple(rand_first(), $urandom(), $urandom());
    drain_pipeline();
  endtask

  // Hold the receiver off while the sender streams, so the pipeline backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 200;
    repeat (120) send_triple(rand_first(), $urandom(), $urandom());
    drain_pipeline();
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left <= hold_req;
      hold_req = 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sample_q.size() == 0) begin
        $error("normal_sample: unexpected transaction, actual %0d",
               $signed(out_normal_sample));
        failures++;
      end else begin
        if (out_normal_sample !== sample_q[0]) begin
          $error("normal_sample: expected %0d actual %0d",
                 $signed(sample_q[0]), $signed(out_normal_sample));
          failures++;
        end
        void'(sample_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("normal_accept_reject_sampler_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250, 38, 61);
    test_random(250, 61, 38);
    test_backpressure();
    test_random(250, 0, 0);
    if (sample_q.size() != 0) begin
      $error("normal_sample: %0d expected transactions never arrived", sample_q.size());
      failures++;
    end
    if (failures == 0) $display("normal_accept_reject_sampler_tb: PASS");
    else $display("normal_accept_reject_sampler_tb: FAIL");
    $finish;
  end

endmodule
